// ===== rtl/core/esc_pkg.sv =====
// Shared types, constants, microcode program and calendar tables for the
// epoch-seconds-to-calendar converter. No dependencies.
package esc_pkg;

  localparam int unsigned EpochW = 32;
  localparam int unsigned ZoneW  = 17;
  localparam int unsigned DayW   = 16;
  localparam int unsigned DivW   = 18;
  localparam int unsigned MulInW = 25;
  localparam int unsigned MulW   = 26;
  localparam int unsigned ProdW  = MulInW + MulW;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;
  localparam int unsigned UpcW   = 4;

  localparam logic [7:0]      FirstYear   = 8'd70;
  localparam logic [DayW:0]   WeekdayBias = 17'd4;
  localparam logic [3:0]      LastMonth   = 4'd11;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_SAVE_DAY,
    OP_SAVE_HOUR,
    OP_SAVE_MIN,
    OP_SAVE_WDAY,
    OP_YEAR,
    OP_MONTH,
    OP_DONE
  } op_t;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN,
    DIV_WEEK
  } dsel_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_START,
    COND_YEAR,
    COND_MONTH
  } cond_t;

  typedef logic [UpcW-1:0] upc_t;

  localparam upc_t UPC_IDLE      = 4'd0;
  localparam upc_t UPC_DIV_DAY   = 4'd1;
  localparam upc_t UPC_SAVE_DAY  = 4'd2;
  localparam upc_t UPC_DIV_HOUR  = 4'd3;
  localparam upc_t UPC_SAVE_HOUR = 4'd4;
  localparam upc_t UPC_DIV_MIN   = 4'd5;
  localparam upc_t UPC_SAVE_MIN  = 4'd6;
  localparam upc_t UPC_DIV_WEEK  = 4'd7;
  localparam upc_t UPC_SAVE_WDAY = 4'd8;
  localparam upc_t UPC_YEAR      = 4'd9;
  localparam upc_t UPC_MONTH     = 4'd10;
  localparam upc_t UPC_DONE      = 4'd11;

  typedef struct packed {
    op_t             op;
    dsel_t           dsel;
    cond_t           cond;
    upc_t            next;
  } uword_t;

  typedef struct packed {
    op_t   op;
    dsel_t dsel;
  } dp_ctl_t;

  typedef struct packed {
    logic year_more;
    logic month_more;
  } dp_stat_t;

  typedef struct packed {
    logic [2:0]      pre;
    logic [MulW-1:0] mul;
    logic [5:0]      post;
  } recip_t;

  function automatic uword_t ucode(upc_t addr);
    uword_t w;
    unique case (addr)
      UPC_IDLE:      w = '{OP_LOAD,      DIV_DAY,  COND_START, UPC_DIV_DAY};
      UPC_DIV_DAY:   w = '{OP_DIV,       DIV_DAY,  COND_NONE,  UPC_SAVE_DAY};
      UPC_SAVE_DAY:  w = '{OP_SAVE_DAY,  DIV_DAY,  COND_NONE,  UPC_DIV_HOUR};
      UPC_DIV_HOUR:  w = '{OP_DIV,       DIV_HOUR, COND_NONE,  UPC_SAVE_HOUR};
      UPC_SAVE_HOUR: w = '{OP_SAVE_HOUR, DIV_HOUR, COND_NONE,  UPC_DIV_MIN};
      UPC_DIV_MIN:   w = '{OP_DIV,       DIV_MIN,  COND_NONE,  UPC_SAVE_MIN};
      UPC_SAVE_MIN:  w = '{OP_SAVE_MIN,  DIV_MIN,  COND_NONE,  UPC_DIV_WEEK};
      UPC_DIV_WEEK:  w = '{OP_DIV,       DIV_WEEK, COND_NONE,  UPC_SAVE_WDAY};
      UPC_SAVE_WDAY: w = '{OP_SAVE_WDAY, DIV_WEEK, COND_NONE,  UPC_YEAR};
      UPC_YEAR:      w = '{OP_YEAR,      DIV_DAY,  COND_YEAR,  UPC_MONTH};
      UPC_MONTH:     w = '{OP_MONTH,     DIV_DAY,  COND_MONTH, UPC_DONE};
      UPC_DONE:      w = '{OP_DONE,      DIV_DAY,  COND_NONE,  UPC_IDLE};
      default:       w = '{OP_NOP,       DIV_DAY,  COND_NONE,  UPC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [DivW-1:0] divisor(dsel_t sel);
    logic [DivW-1:0] d;
    unique case (sel)
      DIV_DAY:  d = 18'd86400;
      DIV_HOUR: d = 18'd3600;
      DIV_MIN:  d = 18'd60;
      DIV_WEEK: d = 18'd7;
      default:  d = 18'd86400;
    endcase
    return d;
  endfunction

  // The quotient is ((x >> pre) * mul) >> post, exact over the range of
  // dividends that each split sees.
  function automatic recip_t recip(dsel_t sel);
    recip_t r;
    unique case (sel)
      DIV_DAY:  r = '{3'd7, 26'd50903317, 6'd35};
      DIV_HOUR: r = '{3'd4, 26'd9321,     6'd21};
      DIV_MIN:  r = '{3'd2, 26'd1093,     6'd14};
      DIV_WEEK: r = '{3'd0, 26'd74899,    6'd19};
      default:  r = '{3'd7, 26'd50903317, 6'd35};
    endcase
    return r;
  endfunction

  // Years are counted from 1900; within an 8-bit count the century years are
  // 1900, 2000 and 2100, of which 1900 and 2100 are common years and 2000 a leap year.
  function automatic logic is_leap(logic [7:0] y);
    return (y[1:0] == 2'd0) && (y != 8'd0) && (y != 8'd200);
  endfunction

  function automatic logic [8:0] year_len(logic [7:0] y);
    return is_leap(y) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(logic leap, logic [3:0] m);
    logic [4:0] n;
    case (m)
      4'd1:                     n = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:  n = 5'd30;
      default:                  n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/esc_datapath.sv =====
// Datapath of the converter: reciprocal-multiply divider, year and month
// reduction and the result registers. Driven by the sequencer; depends on esc_pkg.
module esc_datapath (
  input  logic                        clk,
  input  esc_pkg::dp_ctl_t            ctl,
  input  logic [esc_pkg::EpochW-1:0]  epoch_seconds,
  input  logic [esc_pkg::ZoneW-1:0]   zone_offset,
  output esc_pkg::dp_stat_t           stat,
  output logic [5:0]                  second,
  output logic [5:0]                  minute,
  output logic [4:0]                  hour,
  output logic [2:0]                  weekday,
  output logic [7:0]                  years_since_1900,
  output logic [8:0]                  day_of_year,
  output logic [3:0]                  month,
  output logic [4:0]                  day_of_month
);
  import esc_pkg::*;

  logic [EpochW-1:0] acc;
  logic [DayW-1:0]   quot;
  logic [DayW-1:0]   days;

  logic [EpochW-1:0]    shifted;
  recip_t               rc;
  logic [MulInW-1:0]    mul_in;
  logic [ProdW-1:0]     prod;
  logic [DayW-1:0]      quot_next;
  logic [DivW-1:0]      dvs;
  logic [DayW+DivW-1:0] back;
  logic [EpochW-1:0]    rem;
  logic [8:0]           ylen;
  logic [4:0]           mlen;
  logic [DayW:0]        days_biased;

  always_comb begin
    shifted     = epoch_seconds - {{(EpochW-ZoneW){zone_offset[ZoneW-1]}}, zone_offset};
    rc          = recip(ctl.dsel);
    dvs         = divisor(ctl.dsel);
    mul_in      = MulInW'(acc >> rc.pre);
    prod        = {{MulW{1'b0}}, mul_in} * {{MulInW{1'b0}}, rc.mul};
    quot_next   = DayW'(prod >> rc.post);
    back        = {{DivW{1'b0}}, quot} * {{DayW{1'b0}}, dvs};
    rem         = acc - back[EpochW-1:0];
    ylen        = year_len(years_since_1900);
    mlen        = month_len(is_leap(years_since_1900), month);
    days_biased = {1'b0, days} + WeekdayBias;
    stat.year_more  = (days >= DayW'(ylen));
    stat.month_more = (month < LastMonth) && (days >= DayW'(mlen));
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LOAD: begin
        acc <= shifted;
      end
      OP_DIV: begin
        quot <= quot_next;
      end
      OP_SAVE_DAY: begin
        days <= quot;
        acc  <= rem;
      end
      OP_SAVE_HOUR: begin
        hour <= quot[4:0];
        acc  <= rem;
      end
      OP_SAVE_MIN: begin
        minute <= quot[5:0];
        second <= rem[5:0];
        acc    <= {{(EpochW-DayW-1){1'b0}}, days_biased};
      end
      OP_SAVE_WDAY: begin
        weekday          <= rem[2:0];
        years_since_1900 <= FirstYear;
      end
      OP_YEAR: begin
        if (stat.year_more) begin
          days             <= days - DayW'(ylen);
          years_since_1900 <= years_since_1900 + 8'd1;
        end else begin
          day_of_year <= days[8:0];
          month       <= '0;
        end
      end
      OP_MONTH: begin
        if (stat.month_more) begin
          days  <= days - DayW'(mlen);
          month <= month + 4'd1;
        end else begin
          day_of_month <= days[4:0] + 5'd1;
        end
      end
      OP_NOP, OP_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/epoch_seconds_to_calendar_top.sv =====
// Top level of the epoch-seconds-to-calendar converter: microcode sequencer,
// zone offset register with its APB port. Depends on esc_pkg, esc_datapath.
//
// An item is taken when start is high and busy is low. The result appears
// for one cycle with done high, after the day, hour, minute and weekday
// splits, each a reciprocal multiply followed by a remainder step, and the
// year and month loops, which remove one year or one month per cycle. The
// receiver cannot stall: each result must be taken in the cycle in which
// done is high. busy falls in the cycle after done.
module epoch_seconds_to_calendar_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [esc_pkg::AddrW-1:0]   paddr,
  input  logic [esc_pkg::DataW-1:0]   pwdata,
  output logic [esc_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [esc_pkg::EpochW-1:0]  epoch_seconds,
  output logic                        done,
  output logic [5:0]                  second,
  output logic [5:0]                  minute,
  output logic [4:0]                  hour,
  output logic [2:0]                  weekday,
  output logic [7:0]                  years_since_1900,
  output logic [8:0]                  day_of_year,
  output logic [3:0]                  month,
  output logic [4:0]                  day_of_month
);
  import esc_pkg::*;

  logic [ZoneW-1:0] zone_offset;
  upc_t             upc;
  upc_t             upc_next;
  uword_t           uw;
  logic             adv;
  dp_ctl_t          ctl;
  dp_stat_t         stat;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[AddrW-1] == 1'b0);
  assign prdata  = reg_sel ? DataW'(zone_offset) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      zone_offset <= pwdata[ZoneW-1:0];
    end
  end

  always_comb begin
    uw = ucode(upc);
    case (uw.cond)
      COND_START: adv = start;
      COND_YEAR:  adv = !stat.year_more;
      COND_MONTH: adv = !stat.month_more;
      default:    adv = 1'b1;
    endcase
    upc_next = adv ? uw.next : upc;
    ctl.op   = (uw.cond == COND_START && !start) ? OP_NOP : uw.op;
    ctl.dsel = uw.dsel;
    busy     = (upc != UPC_IDLE);
    done     = (uw.op == OP_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  esc_datapath u_datapath (
    .clk              (clk),
    .ctl              (ctl),
    .epoch_seconds    (epoch_seconds),
    .zone_offset      (zone_offset),
    .stat             (stat),
    .second           (second),
    .minute           (minute),
    .hour             (hour),
    .weekday          (weekday),
    .years_since_1900 (years_since_1900),
    .day_of_year      (day_of_year),
    .month            (month),
    .day_of_month     (day_of_month)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a conversion");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("sequencer did not return to idle after a result");

  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> month <= LastMonth && day_of_month != 5'd0 && hour <= 5'd23
             && minute <= 6'd59 && second <= 6'd59 && weekday <= 3'd6)
    else $error("result field out of range");

endmodule

// ===== tb/sv/esc_calendar_checker.sv =====
// Checker for the epoch-seconds-to-calendar converter: follows the zone offset
// through APB writes, predicts every calendar date and compares it on done.
// Depends on esc_pkg for port widths.
module esc_calendar_checker #(
  parameter int ZONE_INDEX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [esc_pkg::AddrW-1:0]   paddr,
  input  logic [esc_pkg::DataW-1:0]   pwdata,
  input  logic [esc_pkg::DataW-1:0]   prdata,
  input  logic                        pready,
  input  logic                        start,
  input  logic                        busy,
  input  logic [esc_pkg::EpochW-1:0]  epoch_seconds,
  input  logic                        done,
  input  logic [5:0]                  second,
  input  logic [5:0]                  minute,
  input  logic [4:0]                  hour,
  input  logic [2:0]                  weekday,
  input  logic [7:0]                  years_since_1900,
  input  logic [8:0]                  day_of_year,
  input  logic [3:0]                  month,
  input  logic [4:0]                  day_of_month,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PrintLimit = 100;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hr;
    logic [2:0] wday;
    logic [7:0] year;
    logic [8:0] yday;
    logic [3:0] mon;
    logic [4:0] mday;
  } calendar_t;

  calendar_t expected_dates[$];
  logic [esc_pkg::ZoneW-1:0] zone;

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic bit leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic calendar_t to_calendar(logic [31:0] epoch, logic [16:0] offset);
    logic [31:0] shifted;
    int unsigned tod;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    int unsigned mlen;
    calendar_t c;
    shifted = epoch - {{15{offset[16]}}, offset};
    tod = shifted % 86400;
    days = shifted / 86400;
    c.sec = 6'(tod % 60);
    c.min = 6'((tod / 60) % 60);
    c.hr = 5'(tod / 3600);
    c.wday = 3'((days + 4) % 7);
    yr = 1970;
    while (days >= (leap_year(yr) ? 366 : 365)) begin
      days -= leap_year(yr) ? 366 : 365;
      yr++;
    end
    c.year = 8'(yr - 1900);
    c.yday = 9'(days);
    mon = 0;
    forever begin
      case (mon)
        1:          mlen = leap_year(yr) ? 29 : 28;
        3, 5, 8, 10: mlen = 30;
        default:    mlen = 31;
      endcase
      if (mon == 11 || days < mlen) break;
      days -= mlen;
      mon++;
    end
    c.mon = 4'(mon);
    c.mday = 5'(days + 1);
    return c;
  endfunction

  task automatic report_fault(string msg);
    if (errors < PrintLimit) $display("%0t ns: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_fault($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    calendar_t want;
    if (rst) begin
      expected_dates.delete();
      zone = '0;
    end else begin
      if (start && !busy) expected_dates.push_back(to_calendar(epoch_seconds, zone));
      if (done) begin
        if (expected_dates.size() == 0) begin
          report_fault("result transfer with no conversion outstanding");
        end else begin
          want = expected_dates.pop_front();
          check_field("second", int'(second), int'(want.sec));
          check_field("minute", int'(minute), int'(want.min));
          check_field("hour", int'(hour), int'(want.hr));
          check_field("weekday", int'(weekday), int'(want.wday));
          check_field("years_since_1900", int'(years_since_1900), int'(want.year));
          check_field("day_of_year", int'(day_of_year), int'(want.yday));
          check_field("month", int'(month), int'(want.mon));
          check_field("day_of_month", int'(day_of_month), int'(want.mday));
        end
      end
      if (psel && penable && pready && int'(paddr >> 2) == ZONE_INDEX) begin
        if (pwrite) begin
          zone = pwdata[esc_pkg::ZoneW-1:0];
        end else begin
          check_field("zone_offset readback", int'(prdata[esc_pkg::ZoneW-1:0]), int'(zone));
        end
      end
    end
    pending <= expected_dates.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the epoch-seconds-to-calendar converter: drives reset,
// zone offset writes and conversion requests, and gives the verdict.
// Depends on esc_pkg, epoch_seconds_to_calendar_top and esc_calendar_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ZoneIndex     = 0;
  localparam int SpareIndex    = 1;
  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 250;
  localparam int BlockItems    = 100;
  localparam int BlocksPerPhase = 5;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [esc_pkg::AddrW-1:0]   paddr = '0;
  logic [esc_pkg::DataW-1:0]   pwdata = '0;
  logic [esc_pkg::DataW-1:0]   prdata;
  logic                        pready;
  logic                        start = 1'b0;
  logic                        busy;
  logic [esc_pkg::EpochW-1:0]  epoch_seconds = '0;
  logic                        done;
  logic [5:0]                  second;
  logic [5:0]                  minute;
  logic [4:0]                  hour;
  logic [2:0]                  weekday;
  logic [7:0]                  years_since_1900;
  logic [8:0]                  day_of_year;
  logic [3:0]                  month;
  logic [4:0]                  day_of_month;

  int                          errors;
  int                          pending;
  int                          quiet_cycles = 0;
  int                          idle_pct = 0;
  logic [esc_pkg::ZoneW-1:0]   zone_now = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  epoch_seconds_to_calendar_top u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .epoch_seconds, .done, .second, .minute, .hour, .weekday,
    .years_since_1900, .day_of_year, .month, .day_of_month
  );

  esc_calendar_checker #(.ZONE_INDEX(ZoneIndex)) u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .epoch_seconds, .done, .second, .minute, .hour, .weekday,
    .years_since_1900, .day_of_year, .month, .day_of_month, .errors, .pending
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_time(logic [31:0] t);
    epoch_seconds <= t;
    forever begin
      start <= ($urandom_range(0, 99) >= idle_pct);
      @(posedge clk);
      if (start && !busy) break;
    end
  endtask

  // Lower start and wait until every outstanding conversion has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic apb_access(bit wr, int index, logic [31:0] data);
    logic [esc_pkg::AddrW-1:0] addr;
    int byte_addr;
    byte_addr = index * 4;
    addr = byte_addr[esc_pkg::AddrW-1:0];
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (wr && index == ZoneIndex) zone_now = data[esc_pkg::ZoneW-1:0];
  endtask

  task automatic set_zone(logic [31:0] data);
    drain_results();
    apb_access(1'b1, ZoneIndex, data);
    apb_access(1'b0, ZoneIndex, '0);
  endtask

  function automatic logic [31:0] pick_time();
    logic [31:0] off;
    logic [31:0] base;
    off = {{15{zone_now[16]}}, zone_now};
    base = $urandom;
    case ($urandom_range(0, 9))
      0, 1: return (base / 86400) * 86400 + off - $urandom_range(0, 1);
      2:    return off + $urandom_range(0, 200) - 100;
      default: return base;
    endcase
  endfunction

  initial begin
    logic [31:0] directed_times[12];
    logic [31:0] phase_extremes[3];
    int signed z;
    directed_times = '{32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
                       32'h5555_5555, 32'd68169600, 32'd31535999, 32'd946684799,
                       32'd951782400, 32'd978220799, 32'd4107542399, 32'd4107542400};
    phase_extremes = '{32'h0001_3B20, 32'd50400, 32'hFFFF_0000};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register reset value, then dates at the field extremes and leap corners.
    apb_access(1'b0, ZoneIndex, '0);
    foreach (directed_times[i]) send_time(directed_times[i]);

    // Local time path: the first seconds of the epoch wrap back to 2106.
    set_zone(32'd25200);
    send_time(32'd0);
    send_time(32'd25199);
    send_time(32'd25200);

    // A write to an unmapped register must leave the offset alone.
    drain_results();
    apb_access(1'b1, SpareIndex, 32'hFFFF_FFFF);
    apb_access(1'b0, ZoneIndex, '0);
    send_time(32'd86400);

    set_zone(32'hFFFF_FFFF & 32'h0001_3B20);
    send_time(32'hFFFF_FFFF);
    send_time(32'hFFFF_3B20);
    set_zone(32'h0000_FFFF);
    send_time(32'd0);
    send_time(32'd65535);
    set_zone(32'hFFFF_0000);
    send_time(32'hFFFF_FFFF);
    send_time(32'hFFFE_FFFF);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 10 : (phase == 1) ? 86 : 0;
      for (int blk = 0; blk < BlocksPerPhase; blk++) begin
        if (blk == 0) begin
          set_zone(phase_extremes[phase]);
        end else if (blk == 1) begin
          set_zone({$urandom} & 32'hFFFF_0000);
        end else begin
          z = $urandom_range(0, 100800) - 50400;
          set_zone({15'($urandom), 17'(z)});
        end
        if ($urandom_range(0, 3) == 0) apb_access(1'b1, SpareIndex, $urandom);
        for (int n = 0; n < BlockItems; n++) begin
          if ($urandom_range(0, 49) == 0) drain_results();
          send_time(pick_time());
        end
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
